// File: sv/bnms_pkg.sv
// ----------------------------------------------------------------------------
// Bump-to-normal Sobel package
// Shared register indexes and sizes.
// ----------------------------------------------------------------------------
package bnms_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUMP_GAIN = 2'd2;

    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

endpackage

// File: sv/bump_to_normal_map_sobel.sv
// ----------------------------------------------------------------------------
// Bump map to normal map (Sobel)
// Frame store of heights; compute items give one RGB normal word.
//
// Channel  Dir  Handshake           Payload
// s_       in   s_valid / s_ready   s_action s_pos_x s_pos_y s_height_value
// m_       out  m_valid / m_ready   m_red m_green m_blue
// cfg      in   cfg_we              cfg_index cfg_data
//
// Store: the word is written as it is taken, and s_ready stays high for the next word.
// Compute: eight neighbor reads, a sum, three squares, 21 square-root steps and
// three 36-step divides on one shared divider, then m_valid rises.
// Synchronous active-low reset clears control; the frame store is not cleared.
// s_ready stays low while an item is at work or a result waits on m_ready.
// ----------------------------------------------------------------------------
module bump_to_normal_map_sobel
    import bnms_pkg::*;
#(
    parameter int MAX_WIDTH = 512,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [8:0]            s_pos_x,
    input  logic [7:0]            s_pos_y,
    input  logic [7:0]            s_height_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_red,
    output logic [7:0]            m_green,
    output logic [7:0]            m_blue,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_SUM, ST_SQ, ST_SQRT, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg;
    logic [9:0]  img_w_reg;
    logic [8:0]  img_h_reg;
    logic [11:0] gain_reg;
    logic [XW-1:0] x_reg, xl_reg, xr_reg;
    logic [YW-1:0] y_reg, yb_reg, yt_reg;
    logic [3:0]  rd_cnt_reg;
    logic [7:0]  nb_reg [8];
    logic signed [11:0] dx_reg, dy_reg;
    logic [41:0] s_reg;
    logic [20:0] n_reg;
    logic [1:0]  comp_reg;
    logic        div_go_reg;
    logic        sq_go_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic        out_valid_reg;

    // effective sizes
    logic [12:0] w_eff, h_eff;
    always_comb begin
        w_eff = (img_w_reg == '0) ? 13'd1 :
                ({3'd0, img_w_reg} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {3'd0, img_w_reg};
        h_eff = (img_h_reg == '0) ? 13'd1 :
                ({4'd0, img_h_reg} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {4'd0, img_h_reg};
    end

    // frame store
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;
    logic [XW-1:0] rx;
    logic [YW-1:0] ry;
    logic [12:0]   sx, sy;

    assign sx = {4'd0, s_pos_x};
    assign sy = {5'd0, s_pos_y};
    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign ram_we = s_valid && s_ready && (s_action == ACT_STORE) && (sx < w_eff) && (sy < h_eff);

    always_comb begin
        case (rd_cnt_reg[2:0])
            3'd0: begin rx = x_reg;  ry = yt_reg; end
            3'd1: begin rx = x_reg;  ry = yb_reg; end
            3'd2: begin rx = xl_reg; ry = y_reg;  end
            3'd3: begin rx = xr_reg; ry = y_reg;  end
            3'd4: begin rx = xl_reg; ry = yt_reg; end
            3'd5: begin rx = xl_reg; ry = yb_reg; end
            3'd6: begin rx = xr_reg; ry = yt_reg; end
            default: begin rx = xr_reg; ry = yb_reg; end
        endcase
        if (state_reg == ST_IDLE) begin
            ram_addr = {sy[YW-1:0], sx[XW-1:0]};
        end else begin
            ram_addr = {ry, rx};
        end
    end

    bnms_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(s_height_value), .rdata(ram_rdata)
    );

    // Sobel gradients (top is row y+1); neighbors tt bb l r tl bl tr br
    logic signed [11:0] dx_c, dy_c;
    always_comb begin
        dx_c = 12'(signed'({4'd0, nb_reg[6]})) - 12'(signed'({4'd0, nb_reg[4]}))
             + 12'(signed'({3'd0, nb_reg[3], 1'b0})) - 12'(signed'({3'd0, nb_reg[2], 1'b0}))
             + 12'(signed'({4'd0, nb_reg[7]})) - 12'(signed'({4'd0, nb_reg[5]}));
        dy_c = 12'(signed'({4'd0, nb_reg[5]})) - 12'(signed'({4'd0, nb_reg[4]}))
             + 12'(signed'({3'd0, nb_reg[1], 1'b0})) - 12'(signed'({3'd0, nb_reg[0], 1'b0}))
             + 12'(signed'({4'd0, nb_reg[7]})) - 12'(signed'({4'd0, nb_reg[6]}));
    end

    // |dx|,|dy| <= 1020, so squares of |c| fit; cz = gain*255
    logic [9:0]  adx, ady;
    logic [19:0] cz;
    logic [19:0] mag_sel;
    assign adx = dx_reg[11] ? 10'(-dx_reg) : dx_reg[9:0];
    assign ady = dy_reg[11] ? 10'(-dy_reg) : dy_reg[9:0];
    assign cz = 20'({gain_reg, 8'd0} - {8'd0, gain_reg});

    always_comb begin
        case (comp_reg)
            2'd0: mag_sel = {2'd0, adx, 8'd0};
            2'd1: mag_sel = {2'd0, ady, 8'd0};
            default: mag_sel = cz;
        endcase
    end

    logic [19:0] sq_a;
    logic [39:0] sq_p;
    assign sq_a = mag_sel;
    assign sq_p = sq_a * sq_a;

    logic        sqrt_done;
    logic [20:0] sqrt_root;
    bnms_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_go_reg), .radicand(s_reg),
        .done(sqrt_done), .root(sqrt_root)
    );

    logic        div_done;
    logic [16:0] div_q;
    bnms_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_go_reg), .mag(mag_sel), .divisor(n_reg),
        .done(div_done), .quot(div_q)
    );

    logic        neg_sel;
    logic [17:0] t_val;
    logic [25:0] byte_p;
    assign neg_sel = (comp_reg == 2'd0) ? dx_reg[11] == 1'b0 && dx_reg != '0 :
                     (comp_reg == 2'd1) ? dy_reg[11] == 1'b0 && dy_reg != '0 : 1'b0;
    assign t_val = neg_sel ? 18'(18'd65536 - {1'b0, div_q}) : 18'(18'd65536 + {1'b0, div_q});
    assign byte_p = {t_val, 8'd0} - {8'd0, t_val};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            img_w_reg <= 10'd512;
            img_h_reg <= 9'd256;
            gain_reg <= 12'd512;
            out_valid_reg <= 1'b0;
            div_go_reg <= 1'b0;
            sq_go_reg <= 1'b0;
        end else begin
            div_go_reg <= 1'b0;
            sq_go_reg <= 1'b0;
            if (cfg_we) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH: img_w_reg <= cfg_data[9:0];
                    REG_IMAGE_HEIGHT: img_h_reg <= cfg_data[8:0];
                    REG_BUMP_GAIN: gain_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready && s_action == ACT_COMPUTE) begin
                        logic [12:0] cx, cy;
                        cx = (sx >= w_eff) ? w_eff - 13'd1 : sx;
                        cy = (sy >= h_eff) ? h_eff - 13'd1 : sy;
                        x_reg <= cx[XW-1:0];
                        y_reg <= cy[YW-1:0];
                        xl_reg <= (cx == '0) ? XW'(w_eff - 13'd1) : XW'(cx - 13'd1);
                        xr_reg <= (cx + 13'd1 >= w_eff) ? XW'(cx + 13'd1 - w_eff) : XW'(cx + 13'd1);
                        yb_reg <= (cy == '0) ? YW'(h_eff - 13'd1) : YW'(cy - 13'd1);
                        yt_reg <= (cy + 13'd1 >= h_eff) ? YW'(cy + 13'd1 - h_eff) : YW'(cy + 13'd1);
                        rd_cnt_reg <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    // read data arrives the cycle after its address
                    if (rd_cnt_reg != '0) begin
                        nb_reg[rd_cnt_reg[2:0] - 3'd1] <= ram_rdata;
                    end
                    rd_cnt_reg <= rd_cnt_reg + 4'd1;
                    if (rd_cnt_reg == 4'd8) begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    dx_reg <= dx_c;
                    dy_reg <= dy_c;
                    s_reg <= '0;
                    comp_reg <= 2'd0;
                    state_reg <= ST_SQ;
                end
                ST_SQ: begin
                    // accumulate one square a cycle through the shared multiplier
                    s_reg <= s_reg + {2'd0, sq_p};
                    comp_reg <= comp_reg + 2'd1;
                    if (comp_reg == 2'd2) begin
                        sq_go_reg <= 1'b1;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sqrt_done) begin
                        n_reg <= sqrt_root;
                        comp_reg <= 2'd0;
                        div_go_reg <= 1'b1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        case (comp_reg)
                            2'd0: red_reg <= byte_p[24:17];
                            2'd1: green_reg <= byte_p[24:17];
                            default: blue_reg <= byte_p[24:17];
                        endcase
                        comp_reg <= comp_reg + 2'd1;
                        if (comp_reg == 2'd2) begin
                            state_reg <= ST_OUT;
                        end else begin
                            div_go_reg <= 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (!out_valid_reg) begin
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_red = red_reg;
    assign m_green = green_reg;
    assign m_blue = blue_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red)) else $error("result dropped");
    a_no_go_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(div_go_reg && sq_go_reg)) else $error("shared units started together");
endmodule

// File: sv/bnms_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read per cycle at the same address, registered read data.
// ----------------------------------------------------------------------------
module bnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: sv/bnms_sqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root
// Two radicand bits per cycle, floor result.
// ----------------------------------------------------------------------------
module bnms_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [41:0] radicand,
    output logic        done,
    output logic [20:0] root
);
    logic [41:0] rem_reg;
    logic [41:0] res_reg;
    logic [41:0] bit_reg;
    logic        busy_reg;
    logic [41:0] trial;

    assign trial = res_reg + bit_reg;
    assign root = res_reg[20:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                rem_reg <= radicand;
                res_reg <= '0;
                bit_reg <= 42'd1 << 40;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (rem_reg >= trial) begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0]) begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end
endmodule

// File: sv/bnms_div.sv
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Computes min((mag << 16) / n, 65536), or 0 for n = 0, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bnms_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [19:0] mag,
    input  logic [20:0] divisor,
    output logic        done,
    output logic [16:0] quot
);
    logic [21:0] rem_reg;
    logic [35:0] num_reg;
    logic [35:0] q_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [21:0] shifted;

    assign shifted = {rem_reg[20:0], num_reg[35]};
    assign quot = (divisor == '0) ? 17'd0 :
                  (q_reg > 36'd65536) ? 17'd65536 : q_reg[16:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                rem_reg <= '0;
                num_reg <= {mag, 16'd0};
                q_reg <= '0;
                cnt_reg <= 6'd36;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                num_reg <= num_reg << 1;
                if (shifted >= {1'b0, divisor}) begin
                    rem_reg <= shifted - {1'b0, divisor};
                    q_reg <= {q_reg[34:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    q_reg <= {q_reg[34:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end
endmodule

// File: bench/tb_bump_to_normal_map_sobel.sv
// ----------------------------------------------------------------------------
// Bump-to-normal Sobel block testbench
// Drives store and compute words into the frame store, predicts each RGB
// normal in fixed point, and checks every result word in order under
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_bump_to_normal_map_sobel
    import bnms_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MW = 512;
    localparam int MH = 256;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_action;
    logic [8:0]            s_pos_x;
    logic [7:0]            s_pos_y;
    logic [7:0]            s_height_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_red;
    logic [7:0]            m_green;
    logic [7:0]            m_blue;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bump_to_normal_map_sobel uut (.*);

    // predictor state
    logic [7:0]  height_img [0:MW*MH-1];
    bit          written    [0:MW*MH-1];
    logic [9:0]  img_w_reg;
    logic [8:0]  img_h_reg;
    logic [11:0] gain_reg;
    rgb_t        normals_due[$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          rx_hold_cycles;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #30_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic int eff_w();
        return (img_w_reg < 1) ? 1 : (img_w_reg > MW) ? MW : int'(img_w_reg);
    endfunction

    function automatic int eff_h();
        return (img_h_reg < 1) ? 1 : (img_h_reg > MH) ? MH : int'(img_h_reg);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic logic [7:0] comp_byte(input longint c, input longint unsigned n);
        longint unsigned mag;
        longint unsigned q;
        longint unsigned t;
        mag = (c < 0) ? -c : c;
        q = (n != 0) ? (mag << 16) / n : 0;
        if (q > 65536) q = 65536;
        t = (c < 0) ? 65536 - q : 65536 + q;
        return 8'((255 * t) >> 17);
    endfunction

    // neighbor index with toroidal wrap around the saturated center
    function automatic int nb_addr(input int x, input int y, input int ddx, input int ddy);
        int w;
        int h;
        w = eff_w();
        h = eff_h();
        return ((y + ddy + h) % h) * MW + ((x + ddx + w) % w);
    endfunction

    function automatic rgb_t sobel_normal(input int xin, input int yin);
        int x;
        int y;
        int dgx;
        int dgy;
        longint cx;
        longint cy;
        longint cz;
        longint unsigned n;
        rgb_t o;
        x = (xin >= eff_w()) ? eff_w() - 1 : xin;
        y = (yin >= eff_h()) ? eff_h() - 1 : yin;
        dgx = height_img[nb_addr(x, y, 1, 1)] - height_img[nb_addr(x, y, -1, 1)]
            + 2 * (height_img[nb_addr(x, y, 1, 0)] - height_img[nb_addr(x, y, -1, 0)])
            + height_img[nb_addr(x, y, 1, -1)] - height_img[nb_addr(x, y, -1, -1)];
        dgy = height_img[nb_addr(x, y, -1, -1)] - height_img[nb_addr(x, y, -1, 1)]
            + 2 * (height_img[nb_addr(x, y, 0, -1)] - height_img[nb_addr(x, y, 0, 1)])
            + height_img[nb_addr(x, y, 1, -1)] - height_img[nb_addr(x, y, 1, 1)];
        cx = -longint'(dgx) * 256;
        cy = -longint'(dgy) * 256;
        cz = longint'(gain_reg) * 255;
        n = floor_sqrt(cx * cx + cy * cy + cz * cz);
        o.red = comp_byte(cx, n);
        o.green = comp_byte(cy, n);
        o.blue = comp_byte(cz, n);
        return o;
    endfunction

    task automatic send_word(input logic act, input int x, input int y, input int hv);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_action = act;
        s_pos_x = 9'(x);
        s_pos_y = 8'(y);
        s_height_value = 8'(hv);
        do @(posedge aclk); while (!s_ready);
        if (act == ACT_STORE) begin
            if (x < eff_w() && y < eff_h()) begin
                height_img[y * MW + x] = 8'(hv);
                written[y * MW + x] = 1'b1;
            end
        end else begin
            normals_due.push_back(sobel_normal(x, y));
        end
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // fill any unwritten neighbor first so no read hits an empty entry
    task automatic compute_at(input int xin, input int yin);
        int x;
        int y;
        int a;
        x = (xin >= eff_w()) ? eff_w() - 1 : xin;
        y = (yin >= eff_h()) ? eff_h() - 1 : yin;
        for (int j = -1; j <= 1; j++)
            for (int i = -1; i <= 1; i++) begin
                a = nb_addr(x, y, i, j);
                if (!written[a]) send_word(ACT_STORE, a % MW, a / MW, $urandom_range(255));
            end
        send_word(ACT_COMPUTE, xin, yin, $urandom_range(255));
    endtask

    task automatic wait_idle();
        wait (normals_due.size() == 0);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        wait_idle();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_DATA_W'(val);
        case (idx)
            REG_IMAGE_WIDTH: img_w_reg = 10'(val);
            REG_IMAGE_HEIGHT: img_h_reg = 9'(val);
            default: gain_reg = 12'(val);
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic set_geometry(input int w, input int h, input int g);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_BUMP_GAIN, g);
    endtask

    task automatic test_directed();
        set_geometry(4, 4, 512);
        for (int y = 0; y < 4; y++)
            for (int x = 0; x < 4; x++) send_word(ACT_STORE, x, y, 0);
        compute_at(1, 1);
        write_reg(REG_BUMP_GAIN, 0);
        compute_at(2, 2);                       // flat with zero gain
        for (int y = 0; y < 4; y++) send_word(ACT_STORE, 2, y, 255);
        send_word(ACT_STORE, 400, 200, 255);    // outside the image: drop
        compute_at(1, 1);
        write_reg(REG_BUMP_GAIN, 4095);
        compute_at(3, 0);                       // wraps on both axes
        compute_at(0, 3);
        compute_at(511, 255);                   // saturates to the last pixel
        write_reg(REG_BUMP_GAIN, 1);
        compute_at(1, 2);
    endtask

    task automatic test_geometry_edges();
        int widths [6] = '{0, 1, 1023, 513, 3, 512};
        int heights[6] = '{0, 1, 511, 257, 5, 256};
        for (int k = 0; k < 6; k++) begin
            set_geometry(widths[k], heights[k], $urandom_range(1, 4095));
            compute_at(0, 0);
            compute_at($urandom_range(511), $urandom_range(255));
            compute_at(511, 255);
        end
    endtask

    task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
        int w;
        int h;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        w = 2 * $urandom_range(1, 8);
        h = 2 * $urandom_range(1, 8);
        if ($urandom_range(3) == 0) w = $urandom_range(1, 1023);
        set_geometry(w, h, $urandom_range(3) == 0 ? $urandom_range(4095) : $urandom_range(64, 1024));
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(1))
                send_word(ACT_STORE, $urandom_range(3) == 0 ? $urandom_range(511)
                          : $urandom_range(eff_w() - 1), $urandom_range(3) == 0
                          ? $urandom_range(255) : $urandom_range(eff_h() - 1),
                          $urandom_range(255));
            else if ($urandom_range(7) == 0)
                compute_at($urandom_range(511), $urandom_range(255));
            else
                compute_at($urandom_range(eff_w() - 1), $urandom_range(eff_h() - 1));
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_geometry(6, 6, 300);
        rx_hold_cycles = 1500;
        for (int k = 0; k < 6; k++) compute_at($urandom_range(5), $urandom_range(5));
        // hold the sender until the block has drained
        wait (normals_due.size() == 0);
        for (int k = 0; k < 6; k++) compute_at($urandom_range(5), $urandom_range(5));
    endtask

    // receiver ready
    always @(negedge aclk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result check
    always @(posedge aclk) begin
        rgb_t want;
        if (aresetn && m_valid && m_ready) begin
            if (normals_due.size() == 0) begin
                report("unexpected word", m_red, 0);
            end else begin
                want = normals_due.pop_front();
                if (m_red !== want.red) report("red", m_red, want.red);
                if (m_green !== want.green) report("green", m_green, want.green);
                if (m_blue !== want.blue) report("blue", m_blue, want.blue);
            end
        end
    end

    initial begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rx_hold_cycles = 0;
        img_w_reg = 10'd512;
        img_h_reg = 9'd256;
        gain_reg = 12'd512;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = ACT_STORE;
        s_pos_x = '0;
        s_pos_y = '0;
        s_height_value = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_geometry_edges();
        test_random(150, 0, 0);
        test_random(120, 79, 0);
        test_random(120, 0, 79);
        test_random(120, 33, 33);
        test_backpressure();
        test_random(80, 0, 0);
        wait (normals_due.size() == 0);
        repeat (300) @(negedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
